>>> hdl/sbedm_pkg.sv
package sbedm_pkg;

  typedef enum logic [2:0] {
    OP_LB  = 3'd0,
    OP_LH  = 3'd1,
    OP_LW  = 3'd2,
    OP_LBU = 3'd3,
    OP_LHU = 3'd4,
    OP_SB  = 3'd5,
    OP_SH  = 3'd6,
    OP_SW  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    SEG_TEXT   = 3'd0,
    SEG_DATA   = 3'd1,
    SEG_HEAP   = 3'd2,
    SEG_STACK  = 3'd3,
    SEG_KERNEL = 3'd4,
    SEG_NONE   = 3'd5
  } seg_t;

  localparam int NUM_SEG   = 5;
  localparam int NUM_LANES = 4;

  localparam logic [2:0] REG_TEXT_BASE   = 3'd0;
  localparam logic [2:0] REG_DATA_BASE   = 3'd1;
  localparam logic [2:0] REG_HEAP_BASE   = 3'd2;
  localparam logic [2:0] REG_STACK_TOP   = 3'd3;
  localparam logic [2:0] REG_KERNEL_BASE = 3'd4;

  localparam logic [31:0] TEXT_BASE_RST   = 32'h0040_0000;
  localparam logic [31:0] DATA_BASE_RST   = 32'h1001_0000;
  localparam logic [31:0] HEAP_BASE_RST   = 32'h1004_0000;
  localparam logic [31:0] STACK_TOP_RST   = 32'h7FFF_FFFC;
  localparam logic [31:0] KERNEL_BASE_RST = 32'h8000_0000;

  // control shared by all segment stores
  typedef struct packed {
    logic clearing;
    logic advance;
    logic store;
  } ctl_t;

  function automatic logic [2:0] op_bytes(op_t op);
    logic [2:0] n;
    case (op)
      OP_LB, OP_LBU, OP_SB: n = 3'd1;
      OP_LH, OP_LHU, OP_SH: n = 3'd2;
      default:              n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic op_is_store(op_t op);
    return op inside {OP_SB, OP_SH, OP_SW};
  endfunction

endpackage

>>> hdl/sbedm_ram.sv
module sbedm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> hdl/sbedm_store.sv
// One segment store, split into four byte banks by index modulo four.
module sbedm_store
  import sbedm_pkg::*;
#(
  parameter int BYTES = 4096,
  parameter int CLR_W = 10
) (
  input  logic                           clk,
  input  ctl_t                           ctl,
  input  logic [CLR_W-1:0]               clr_addr,
  input  logic [NUM_LANES-1:0]           hit,
  input  logic [NUM_LANES-1:0][31:0]     offset,
  input  logic [NUM_LANES-1:0][7:0]      wbyte,
  output logic [NUM_LANES-1:0][7:0]      rdata
);

  localparam int DEPTH = (BYTES + 3) / 4;
  localparam int RW    = $clog2(DEPTH);

  logic clr_in;

  assign clr_in = {1'b0, clr_addr} < (CLR_W + 1)'(DEPTH);

  for (genvar b = 0; b < NUM_LANES; b++) begin : g_bank
    logic          sel_any;
    logic [RW-1:0] row;
    logic [7:0]    data;
    logic          ram_en;
    logic          ram_we;
    logic [RW-1:0] ram_addr;
    logic [7:0]    ram_wdata;

    // consecutive indices of one item never share a bank
    always_comb begin
      sel_any = 1'b0;
      row     = '0;
      data    = '0;
      for (int j = 0; j < NUM_LANES; j++) begin
        if (hit[j] && offset[j][1:0] == 2'(b)) begin
          sel_any = 1'b1;
          row     = offset[j][RW+1:2];
          data    = wbyte[j];
        end
      end
    end

    assign ram_en    = ctl.clearing ? clr_in : (ctl.advance && sel_any);
    assign ram_we    = ctl.clearing ? clr_in : ctl.store;
    assign ram_addr  = ctl.clearing ? clr_addr[RW-1:0] : row;
    assign ram_wdata = ctl.clearing ? 8'h00 : data;

    sbedm_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (rdata[b])
    );
  end

endmodule

>>> hdl/segmented_big_endian_data_memory.sv
// Path from item acceptance to result valid: the input register loads on
// acceptance, then a registered bank read, then the result register.
// Throughput: one item per cycle while m_tready does not stall the output.
// Reset: segment base registers take their default values, then a clearing
// pass zeroes every byte bank, one row per cycle, over ceil(max bytes / 4)
// rows (1024 at default sizes); s_tready stays low during the pass.
module segmented_big_endian_data_memory
  import sbedm_pkg::*;
#(
  parameter int TEXT_BYTES   = 4096,
  parameter int DATA_BYTES   = 4096,
  parameter int HEAP_BYTES   = 4096,
  parameter int STACK_BYTES  = 4096,
  parameter int KERNEL_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // operation[2:0], address[34:3], store_data[66:35]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // load_data[31:0], fault[32]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SEG_BYTES [NUM_SEG] = '{TEXT_BYTES, DATA_BYTES, HEAP_BYTES,
                                         STACK_BYTES, KERNEL_BYTES};
  localparam int D0   = (TEXT_BYTES + 3) / 4;
  localparam int D1   = (DATA_BYTES + 3) / 4;
  localparam int D2   = (HEAP_BYTES + 3) / 4;
  localparam int D3   = (STACK_BYTES + 3) / 4;
  localparam int D4   = (KERNEL_BYTES + 3) / 4;
  localparam int M01  = (D0 > D1) ? D0 : D1;
  localparam int M23  = (D2 > D3) ? D2 : D3;
  localparam int M03  = (M01 > M23) ? M01 : M23;
  localparam int MAXD = (M03 > D4) ? M03 : D4;
  localparam int CLR_W = $clog2(MAXD);

  // configuration
  logic [31:0] text_base;
  logic [31:0] data_base;
  logic [31:0] heap_base;
  logic [31:0] stack_top;
  logic [31:0] kernel_base;

  // clearing pass
  logic             clearing;
  logic [CLR_W-1:0] clr_cnt;

  // pipeline
  logic en1, en2, en3;
  logic        v1;
  op_t         op1;
  logic [31:0] addr1;
  logic [31:0] sdata1;

  logic              v2;
  op_t               op2;
  logic              fault2;
  seg_t [NUM_LANES-1:0]     seg2;
  logic [NUM_LANES-1:0][1:0] bank2;

  logic        ov;
  logic [31:0] load_data;
  logic        fault;

  // stage 1 decode
  logic [2:0]                    n1;
  logic                          st1;
  logic                          fault1;
  logic [NUM_LANES-1:0]          active;
  logic [NUM_LANES-1:0][31:0]    lane_addr;
  logic [32:0]                   dif [NUM_SEG][NUM_LANES];
  logic [31:0]                   seg_base [NUM_SEG];
  seg_t [NUM_LANES-1:0]          seg1;
  logic [NUM_LANES-1:0][7:0]     wbyte;
  logic [NUM_LANES-1:0]          hit [NUM_SEG];
  logic [NUM_LANES-1:0][31:0]    offset [NUM_SEG];
  logic [NUM_LANES-1:0][7:0]     rd [NUM_SEG];
  ctl_t                          ctl;

  // stage 2 assembly
  logic [NUM_LANES-1:0][7:0] lane_byte;
  logic [2:0]                n2;
  logic [31:0]               value;

  assign en3      = !ov || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1 && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_base   <= TEXT_BASE_RST;
      data_base   <= DATA_BASE_RST;
      heap_base   <= HEAP_BASE_RST;
      stack_top   <= STACK_TOP_RST;
      kernel_base <= KERNEL_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_BASE:   text_base   <= cfg_data;
        REG_DATA_BASE:   data_base   <= cfg_data;
        REG_HEAP_BASE:   heap_base   <= cfg_data;
        REG_STACK_TOP:   stack_top   <= cfg_data;
        REG_KERNEL_BASE: kernel_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLR_W'(MAXD - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid && s_tready;
      if (en2) v2 <= v1;
      if (en3) ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1    <= op_t'(s_tdata[2:0]);
      addr1  <= s_tdata[34:3];
      sdata1 <= s_tdata[66:35];
    end
    if (en2) begin
      op2    <= op1;
      fault2 <= fault1;
      seg2   <= seg1;
      for (int j = 0; j < NUM_LANES; j++) begin
        bank2[j] <= dif[seg1[j] == SEG_NONE ? SEG_TEXT : seg1[j]][j][1:0];
      end
    end
    if (en3) begin
      load_data <= value;
      fault     <= fault2;
    end
  end

  assign seg_base[0] = text_base;
  assign seg_base[1] = data_base;
  assign seg_base[2] = heap_base;
  assign seg_base[3] = stack_top;
  assign seg_base[4] = kernel_base;

  always_comb begin
    n1     = op_bytes(op1);
    st1    = op_is_store(op1);
    fault1 = 1'b0;
    for (int j = 0; j < NUM_LANES; j++) begin
      lane_addr[j] = addr1 + 32'(j);
      active[j]    = 3'(j) < n1;
      seg1[j]      = SEG_NONE;
      for (int s = NUM_SEG - 1; s >= 0; s--) begin
        // the stack counts down from its top, the others up from their base
        if (s == int'(SEG_STACK)) begin
          dif[s][j] = {1'b0, seg_base[s]} - {1'b0, lane_addr[j]};
        end else begin
          dif[s][j] = {1'b0, lane_addr[j]} - {1'b0, seg_base[s]};
        end
        if (!dif[s][j][32] && dif[s][j][31:0] < 32'(SEG_BYTES[s])) begin
          seg1[j] = seg_t'(3'(s));
        end
      end
      if (active[j] && seg1[j] == SEG_NONE) begin
        fault1 = 1'b1;
      end
      wbyte[j] = 8'(sdata1 >> {2'(n1 - 3'd1 - 3'(j)), 3'b000});
    end
    for (int s = 0; s < NUM_SEG; s++) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        hit[s][j]    = v1 && !fault1 && active[j] && seg1[j] == seg_t'(3'(s));
        offset[s][j] = dif[s][j][31:0];
      end
    end
  end

  assign ctl.clearing = clearing;
  assign ctl.advance  = en2;
  assign ctl.store    = st1;

  for (genvar s = 0; s < NUM_SEG; s++) begin : g_seg
    sbedm_store #(
      .BYTES (SEG_BYTES[s]),
      .CLR_W (CLR_W)
    ) u_store (
      .clk      (clk),
      .ctl      (ctl),
      .clr_addr (clr_cnt),
      .hit      (hit[s]),
      .offset   (offset[s]),
      .wbyte    (wbyte),
      .rdata    (rd[s])
    );
  end

  always_comb begin
    n2 = op_bytes(op2);
    for (int j = 0; j < NUM_LANES; j++) begin
      if (seg2[j] == SEG_NONE) begin
        lane_byte[j] = 8'h00;
      end else begin
        lane_byte[j] = rd[seg2[j]][bank2[j]];
      end
    end
    case (n2)
      3'd1:    value = {24'h0, lane_byte[0]};
      3'd2:    value = {16'h0, lane_byte[0], lane_byte[1]};
      default: value = {lane_byte[0], lane_byte[1], lane_byte[2], lane_byte[3]};
    endcase
    if (op2 == OP_LB && value[7]) begin
      value[31:8] = 24'hFF_FFFF;
    end else if (op2 == OP_LH && value[15]) begin
      value[31:16] = 16'hFFFF;
    end
    if (fault2 || op_is_store(op2)) begin
      value = '0;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {7'b0, fault, load_data};

endmodule

>>> hdl/sbedm_checker.sv
module sbedm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'h0)
    else $error("faulting item returned nonzero data");

  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("item path open right after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("accepted item did not reach the output");

endmodule

bind segmented_big_endian_data_memory sbedm_checker u_checker (.*);

>>> tb/testbench.sv
module testbench;
  import sbedm_pkg::*;

  localparam int SEG_BYTES = 4096;
  localparam int IDLE_LIMIT = 5000;
  localparam int NUM_PHASES = 8;
  localparam int NUM_DIRECTED = 25;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0] load_data;
    logic        fault;
  } access_t;

  typedef struct {
    op_t         op;
    logic [31:0] addr;
    logic [31:0] wdata;
    bit          typed;
    logic [31:0] want_data;
    logic        want_fault;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // operation[2:0], address[34:3], store_data[66:35]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // load_data[31:0], fault[32]
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  segmented_big_endian_data_memory dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] seg_base [NUM_SEG];
  logic [7:0]  bank [NUM_SEG][SEG_BYTES];
  access_t     predicted_access [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          calm_in = 0;
  int          calm_out = 0;

  directed_row_t directed_rows [NUM_DIRECTED];
  logic [31:0]   layout [NUM_PHASES][NUM_SEG];
  int            phase_items [NUM_PHASES];

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // priority decode; stack is indexed downward from its top
  function automatic seg_t find_segment(input logic [31:0] a, output logic [11:0] idx);
    logic        hit;
    logic [31:0] off;
    idx = '0;
    for (int s = 0; s < NUM_SEG; s++) begin
      if (s == SEG_STACK) begin
        hit = a <= seg_base[s];
        off = seg_base[s] - a;
      end else begin
        hit = a >= seg_base[s];
        off = a - seg_base[s];
      end
      if (hit && off < SEG_BYTES) begin
        idx = off[11:0];
        return seg_t'(s);
      end
    end
    return SEG_NONE;
  endfunction

  function automatic access_t access_memory(op_t op, logic [31:0] addr, logic [31:0] wdata);
    access_t     r;
    int          n;
    seg_t        seg [4];
    logic [11:0] idx [4];
    logic [31:0] v;
    r = '0;
    case (op)
      OP_LB, OP_LBU, OP_SB: n = 1;
      OP_LH, OP_LHU, OP_SH: n = 2;
      default:              n = 4;
    endcase
    for (int i = 0; i < n; i++) begin
      seg[i] = find_segment(addr + 32'(i), idx[i]);
      if (seg[i] == SEG_NONE) begin
        r.fault = 1'b1;
        return r;
      end
    end
    if (op inside {OP_SB, OP_SH, OP_SW}) begin
      for (int i = 0; i < n; i++)
        bank[seg[i]][idx[i]] = 8'(wdata >> (8 * (n - 1 - i)));
      return r;
    end
    v = '0;
    for (int i = 0; i < n; i++)
      v = {v[23:0], bank[seg[i]][idx[i]]};
    if (op == OP_LB)
      v = {{24{v[7]}}, v[7:0]};
    else if (op == OP_LH)
      v = {{16{v[15]}}, v[15:0]};
    r.load_data = v;
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx <= REG_KERNEL_BASE)
      seg_base[idx] = val;
  endtask

  task automatic send_item(input op_t op, input logic [31:0] addr, input logic [31:0] wdata,
                           input bit typed, input logic [31:0] want_data,
                           input logic want_fault);
    int      gap;
    access_t got;
    gap = draw_gap(calm_in);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, wdata, addr, op};
    do @(posedge clk); while (s_tready !== 1'b1);
    got = access_memory(op, addr, wdata);
    if (typed)
      predicted_access.push_back({want_data, want_fault});
    else
      predicted_access.push_back(got);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (predicted_access.size() != 0) @(posedge clk);
  endtask

  task automatic send_random;
    int          r;
    int          s;
    logic [31:0] off;
    logic [31:0] addr;
    logic [31:0] wdata;
    op_t         op;
    r = $urandom_range(0, 99);
    op = op_t'($urandom_range(0, 7));
    if (r < 10) begin
      addr = $urandom();
    end else begin
      s = $urandom_range(0, NUM_SEG - 1);
      if (r < 65)
        off = $urandom_range(0, 31);
      else if (r < 85)
        off = $urandom_range(0, SEG_BYTES - 1);
      else if ($urandom_range(0, 1) == 1)
        off = SEG_BYTES - 4 + $urandom_range(0, 7);
      else
        off = -$urandom_range(1, 4);
      addr = (s == SEG_STACK) ? seg_base[s] - off : seg_base[s] + off;
    end
    case ($urandom_range(0, 19))
      0:       wdata = 32'h0000_0000;
      1:       wdata = 32'hFFFF_FFFF;
      2:       wdata = 32'h8080_8080;
      default: wdata = $urandom();
    endcase
    send_item(op, addr, wdata, 1'b0, '0, 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int      gap;
    access_t want;
    wait (rst == 1'b0);
    forever begin
      gap = draw_gap(calm_out);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if (predicted_access.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with none pending: data %h fault %b", m_tdata[31:0], m_tdata[32]);
      end else begin
        want = predicted_access.pop_front();
        if (m_tdata[31:0] !== want.load_data || m_tdata[32] !== want.fault) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected data %h fault %b, got data %h fault %b",
                     want.load_data, want.fault, m_tdata[31:0], m_tdata[32]);
        end
      end
    end
  end

  initial begin
    logic [31:0] anchor;
    for (int s = 0; s < NUM_SEG; s++)
      for (int i = 0; i < SEG_BYTES; i++)
        bank[s][i] = '0;
    seg_base[REG_TEXT_BASE] = TEXT_BASE_RST;
    seg_base[REG_DATA_BASE] = DATA_BASE_RST;
    seg_base[REG_HEAP_BASE] = HEAP_BASE_RST;
    seg_base[REG_STACK_TOP] = STACK_TOP_RST;
    seg_base[REG_KERNEL_BASE] = KERNEL_BASE_RST;

    directed_rows = '{
      '{OP_LW,  32'h0040_0000, 32'h0000_0000, 1, 32'h0, 1'b0},
      '{OP_LW,  32'h8000_0FFC, 32'h0000_0000, 1, 32'h0, 1'b0},
      '{OP_LB,  32'h0000_0000, 32'h0000_0000, 1, 32'h0, 1'b1},
      '{OP_LW,  32'hFFFF_FFFE, 32'hFFFF_FFFF, 1, 32'h0, 1'b1},
      '{OP_LBU, 32'hFFFF_FFFF, 32'h0000_0000, 1, 32'h0, 1'b1},
      '{OP_SW,  32'h0040_0000, 32'h80FF_7F01, 1, 32'h0, 1'b0},
      '{OP_LW,  32'h0040_0000, 32'h0000_0000, 0, 32'h0, 1'b0},
      '{OP_LB,  32'h0040_0000, 32'h0000_0000, 0, 32'h0, 1'b0},
      '{OP_LBU, 32'h0040_0000, 32'h0000_0000, 0, 32'h0, 1'b0},
      '{OP_LH,  32'h0040_0000, 32'h0000_0000, 0, 32'h0, 1'b0},
      '{OP_LHU, 32'h0040_0000, 32'h0000_0000, 0, 32'h0, 1'b0},
      '{OP_LH,  32'h0040_0002, 32'h0000_0000, 0, 32'h0, 1'b0},
      // crosses the top of the stack into unmapped space
      '{OP_SH,  32'h7FFF_FFFC, 32'hFFFF_8001, 1, 32'h0, 1'b1},
      '{OP_SH,  32'h7FFF_FFFB, 32'h0000_1234, 1, 32'h0, 1'b0},
      '{OP_LHU, 32'h7FFF_FFFB, 32'h0000_0000, 0, 32'h0, 1'b0},
      '{OP_LB,  32'h7FFF_FFFC, 32'h0000_0000, 0, 32'h0, 1'b0},
      // faulting store past the text end writes nothing
      '{OP_SW,  32'h0040_0FFE, 32'hFFFF_FFFF, 1, 32'h0, 1'b1},
      '{OP_LW,  32'h0040_0FFC, 32'h0000_0000, 0, 32'h0, 1'b0},
      '{OP_SB,  32'h8000_0FFF, 32'hFFFF_FFAB, 1, 32'h0, 1'b0},
      '{OP_LB,  32'h8000_0FFF, 32'h0000_0000, 0, 32'h0, 1'b0},
      '{OP_SW,  32'h1004_0FFC, 32'hFFFF_FFFF, 1, 32'h0, 1'b0},
      '{OP_LW,  32'h1004_0FFC, 32'h0000_0000, 0, 32'h0, 1'b0},
      '{OP_SW,  32'h7FFF_EFFD, 32'hCAFE_5A5A, 1, 32'h0, 1'b0},
      '{OP_LW,  32'h7FFF_EFFC, 32'h0000_0000, 1, 32'h0, 1'b1},
      '{OP_LBU, 32'h1001_0FFF, 32'h0000_0000, 1, 32'h0, 1'b0}
    };

    layout[0] = '{TEXT_BASE_RST, DATA_BASE_RST, HEAP_BASE_RST, STACK_TOP_RST, KERNEL_BASE_RST};
    // every segment on top of the others
    layout[1] = '{32'h0000_2000, 32'h0000_2000, 32'h0000_2000, 32'h0000_2FFF, 32'h0000_2000};
    layout[2] = '{32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0FFC};
    // stack holds only address zero; text ends at the top of the address space
    layout[3] = '{32'hFFFF_FFFE, 32'h0000_1000, 32'h7FFF_F800, 32'h0000_0000, 32'hFFFF_FF00};
    for (int p = 4; p < 7; p++) begin
      anchor = $urandom();
      for (int s = 0; s < NUM_SEG; s++)
        layout[p][s] = anchor + $urandom_range(0, 16383);
    end
    layout[7] = layout[0];
    phase_items = '{300, 200, 250, 250, 200, 200, 200, 100};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (s_tready !== 1'b1);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].wdata,
                directed_rows[i].typed, directed_rows[i].want_data,
                directed_rows[i].want_fault);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      for (int s = 0; s < NUM_SEG; s++)
        write_reg(3'(s), layout[p][s]);
      // indexes past the last register are ignored
      write_reg(3'($urandom_range(NUM_SEG, 7)), $urandom());
      cfg_we <= 1'b0;
      for (int i = 0; i < phase_items[p]; i++)
        send_random();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
